[rtl/core/scpf_pkg.sv]
`timescale 1ns / 1ps

package scpf_pkg;

  localparam int unsigned ModeW   = 4;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned DlenW   = 3;

  localparam logic [CrcW-1:0]  CrcPoly   = 16'h8005;
  localparam logic [ByteW-1:0] InstrWrite = 8'h03;
  localparam logic [ByteW-1:0] InstrRead  = 8'h02;
  localparam logic [ByteW-1:0] ServoIdRst = 8'h01;
  localparam logic [ByteW-1:0] ReadSize   = 8'h04;

  localparam logic [ModeW-1:0] ModeOpMode  = 4'd0;
  localparam logic [ModeW-1:0] ModeTorque  = 4'd1;
  localparam logic [ModeW-1:0] ModePos     = 4'd2;
  localparam logic [ModeW-1:0] ModeVel     = 4'd3;
  localparam logic [ModeW-1:0] ModePwm     = 4'd4;
  localparam logic [ModeW-1:0] ModePGain   = 4'd5;
  localparam logic [ModeW-1:0] ModeDGain   = 4'd6;
  localparam logic [ModeW-1:0] ModeVelLim  = 4'd7;
  localparam logic [ModeW-1:0] ModeReadPos = 4'd8;
  localparam logic [ModeW-1:0] ModeCount   = 4'd9;

  localparam logic [IdxW-1:0] IdxHdr0    = 4'd0;
  localparam logic [IdxW-1:0] IdxHdr1    = 4'd1;
  localparam logic [IdxW-1:0] IdxHdr2    = 4'd2;
  localparam logic [IdxW-1:0] IdxHdr3    = 4'd3;
  localparam logic [IdxW-1:0] IdxId      = 4'd4;
  localparam logic [IdxW-1:0] IdxLenLo   = 4'd5;
  localparam logic [IdxW-1:0] IdxLenHi   = 4'd6;
  localparam logic [IdxW-1:0] IdxInstr   = 4'd7;
  localparam logic [IdxW-1:0] IdxAddrLo  = 4'd8;
  localparam logic [IdxW-1:0] IdxAddrHi  = 4'd9;
  localparam logic [IdxW-1:0] IdxData0   = 4'd10;
  localparam logic [IdxW-1:0] IdxData1   = 4'd11;
  localparam logic [IdxW-1:0] IdxData2   = 4'd12;
  localparam logic [IdxW-1:0] IdxData3   = 4'd13;

  typedef enum logic [1:0] {
    StIdle,
    StBody,
    StCrcLo,
    StCrcHi
  } seq_state_e;

  typedef struct packed {
    logic             clear;
    logic             update;
    logic [ByteW-1:0] data;
  } crc_req_t;

  typedef struct packed {
    logic             load;
    logic [ByteW-1:0] data;
    logic             last;
  } out_req_t;

  function automatic logic [DlenW-1:0] mode_data_len(input logic [ModeW-1:0] mode);
    logic [DlenW-1:0] len;
    case (mode)
      ModeOpMode, ModeTorque:          len = 3'd1;
      ModePos, ModeVel, ModeVelLim:    len = 3'd4;
      ModePwm, ModePGain, ModeDGain:   len = 3'd2;
      ModeReadPos:                     len = 3'd2;
      default:                         len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [ByteW-1:0] mode_addr(input logic [ModeW-1:0] mode);
    logic [ByteW-1:0] addr;
    case (mode)
      ModeOpMode:  addr = 8'd11;
      ModeTorque:  addr = 8'h40;
      ModePos:     addr = 8'h74;
      ModeVel:     addr = 8'd104;
      ModePwm:     addr = 8'd100;
      ModePGain:   addr = 8'd84;
      ModeDGain:   addr = 8'd80;
      ModeVelLim:  addr = 8'd44;
      ModeReadPos: addr = 8'd132;
      default:     addr = 8'd0;
    endcase
    return addr;
  endfunction

  function automatic logic [ByteW-1:0] frame_byte(
    input logic [IdxW-1:0]   idx,
    input logic [ModeW-1:0]  mode,
    input logic [ValueW-1:0] value,
    input logic [ByteW-1:0]  servo_id
  );
    logic [ByteW-1:0] b;
    logic             rd;
    rd = (mode == ModeReadPos);
    case (idx)
      IdxHdr0, IdxHdr1: b = 8'hFF;
      IdxHdr2:          b = 8'hFD;
      IdxHdr3:          b = 8'h00;
      IdxId:            b = servo_id;
      IdxLenLo:         b = {{(ByteW-DlenW){1'b0}}, mode_data_len(mode)} + 8'd5;
      IdxLenHi:         b = 8'h00;
      IdxInstr:         b = rd ? InstrRead : InstrWrite;
      IdxAddrLo:        b = mode_addr(mode);
      IdxAddrHi:        b = 8'h00;
      IdxData0:         b = rd ? ReadSize : value[7:0];
      IdxData1:         b = rd ? 8'h00 : value[15:8];
      IdxData2:         b = value[23:16];
      IdxData3:         b = value[31:24];
      default:          b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [CrcW-1:0] crc_next(
    input logic [CrcW-1:0]  crc,
    input logic [ByteW-1:0] data
  );
    logic [CrcW-1:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < ByteW; k++) begin
      c = c[CrcW-1] ? ({c[CrcW-2:0], 1'b0} ^ CrcPoly) : {c[CrcW-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/core/scpf_ifs.sv]
`timescale 1ns / 1ps

interface scpf_cmd_if
  import scpf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic        [ModeW-1:0]  mode;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface scpf_byte_if
  import scpf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] packet_byte;
  logic             last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

[rtl/core/scpf_crc_unit.sv]
`timescale 1ns / 1ps

module scpf_crc_unit
  import scpf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crc_req_t        req_i,
  output logic [CrcW-1:0] crc_o
);

  logic [CrcW-1:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (req_i.clear) begin
      crc_d = '0;
    end else if (req_i.update) begin
      crc_d = crc_next(crc_q, req_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

[rtl/core/scpf_seq.sv]
`timescale 1ns / 1ps

module scpf_seq
  import scpf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  logic [ModeW-1:0]  cmd_mode_i,
  input  logic [ValueW-1:0] cmd_value_i,
  input  logic [ByteW-1:0]  servo_id_i,
  input  logic              out_free_i,
  output logic              cmd_ready_o,
  output out_req_t          out_req_o
);

  seq_state_e        state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [ModeW-1:0]  mode_q, mode_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [IdxW-1:0]   last_idx;
  logic [CrcW-1:0]   crc;
  crc_req_t          crc_req;

  scpf_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (crc_req),
    .crc_o  (crc)
  );

  assign last_idx = IdxAddrHi + {{(IdxW-DlenW){1'b0}}, mode_data_len(mode_q)};

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    mode_d      = mode_q;
    value_d     = value_q;
    cmd_ready_o = 1'b0;
    out_req_o   = '{load: 1'b0, data: '0, last: 1'b0};
    crc_req     = '{clear: 1'b0, update: 1'b0, data: '0};
    case (state_q)
      StIdle: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          mode_d  = cmd_mode_i;
          value_d = cmd_value_i;
          if (cmd_mode_i < ModeCount) begin
            state_d       = StBody;
            idx_d         = IdxHdr0;
            crc_req.clear = 1'b1;
          end
        end
      end
      StBody: begin
        if (out_free_i) begin
          out_req_o.load = 1'b1;
          out_req_o.data = frame_byte(idx_q, mode_q, value_q, servo_id_i);
          crc_req.update = 1'b1;
          crc_req.data   = out_req_o.data;
          if (idx_q == last_idx) begin
            state_d = StCrcLo;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      StCrcLo: begin
        if (out_free_i) begin
          out_req_o.load = 1'b1;
          out_req_o.data = crc[ByteW-1:0];
          state_d        = StCrcHi;
        end
      end
      StCrcHi: begin
        if (out_free_i) begin
          out_req_o.load = 1'b1;
          out_req_o.data = crc[CrcW-1:ByteW];
          out_req_o.last = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    value_q <= value_d;
  end

endmodule

[rtl/core/servo_command_packet_framer.sv]
`timescale 1ns / 1ps

// Frames one servo command per request into an instruction packet of 13 to 16 bytes
// (header, servo id, length, instruction, address, data, CRC-16 low then high byte),
// sent one byte per cycle while the output is not stalled, with the final CRC byte
// flagged. A command is accepted first, and its packet bytes then come in order from
// the byte sequencer and its byte-wide CRC unit.
// The input is not ready while a packet is being sent. A mode with no command is
// accepted and produces no bytes. The servo id register may be written while idle.

module servo_command_packet_framer
  import scpf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  scpf_cmd_if.sink         cmd_i,
  scpf_byte_if.source      pkt_o
);

  logic [ByteW-1:0] servo_id_q, servo_id_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_free;
  out_req_t         out_req;

  assign out_free = !out_valid_q || pkt_o.ready;

  scpf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_mode_i  (cmd_i.mode),
    .cmd_value_i (cmd_i.value),
    .servo_id_i  (servo_id_q),
    .out_free_i  (out_free),
    .cmd_ready_o (cmd_i.ready),
    .out_req_o   (out_req)
  );

  always_comb begin
    servo_id_d  = cfg_we_i ? cfg_wdata_i : servo_id_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (out_req.load) begin
      out_valid_d = 1'b1;
      out_byte_d  = out_req.data;
      out_last_d  = out_req.last;
    end else if (pkt_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_id_q  <= ServoIdRst;
      out_valid_q <= 1'b0;
    end else begin
      servo_id_q  <= servo_id_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign pkt_o.valid       = out_valid_q;
  assign pkt_o.packet_byte = out_byte_q;
  assign pkt_o.last_byte   = out_last_q;

endmodule

[rtl/core/scpf_checker.sv]
`timescale 1ns / 1ps

module scpf_checker
  import scpf_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [ModeW-1:0] in_mode_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_i,
  input logic             out_last_i
);

  // A request with a real command keeps the input busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i < ModeCount) |=> !in_ready_i)
    else $error("input still ready after a command request");

  // The input only goes busy right after it took a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && in_ready_i))
    else $error("input went busy without a request");

  // A request with an unused mode leaves the input ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i >= ModeCount) |=> in_ready_i)
    else $error("unused mode made the input busy");

  // A stalled output byte holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled output byte changed");

endmodule

bind servo_command_packet_framer scpf_checker u_scpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .in_mode_i   (cmd_i.mode),
  .out_valid_i (pkt_o.valid),
  .out_ready_i (pkt_o.ready),
  .out_byte_i  (pkt_o.packet_byte),
  .out_last_i  (pkt_o.last_byte)
);
